>>> src/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and constants of the CIDR scope parser.
// ----------------------------------------------------------------------------
package csp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCOPE_MODE    = 2'd0,
        CFG_MAX_HOSTS     = 2'd1,
        CFG_PERMIT_REMOTE = 2'd2,
        CFG_CONFIRMED     = 2'd3
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK              = 4'd0,
        ST_NO_PREFIX       = 4'd1,
        ST_BAD_ADDR        = 4'd2,
        ST_BAD_PREFIX_CHAR = 4'd3,
        ST_PREFIX_OVER     = 4'd4,
        ST_CAP_EXCEEDED    = 4'd5,
        ST_NON_LOCAL       = 4'd6,
        ST_NOT_ALLOWED     = 4'd7,
        ST_NOT_CONFIRMED   = 4'd8
    } t_status;

    // Sticky prefix error
    typedef enum logic [1:0] {
        PERR_NONE = 2'd0,
        PERR_CHAR = 2'd1,
        PERR_OVER = 2'd2
    } t_perr;

    // Scope modes
    localparam logic MODE_CUSTOM  = 1'b0;
    localparam logic MODE_ADAPTER = 1'b1;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Limits and reset values
    localparam logic [11:0] OCTET_MAX      = 12'd255;
    localparam logic [9:0]  PREFIX_MAX     = 10'd32;
    localparam logic [5:0]  PREFIX_FULL    = 6'd32;
    localparam logic [5:0]  ADAPTER_PREFIX = 6'd24;
    localparam logic [1:0]  LAST_DOT       = 2'd3;
    localparam logic [31:0] MAX_HOSTS_RST  = 32'd256;

    // Private ranges
    localparam logic [31:0] PRIV_A_MASK = 32'hFF00_0000;
    localparam logic [31:0] PRIV_A_NET  = 32'h0A00_0000;
    localparam logic [31:0] PRIV_B_MASK = 32'hFFF0_0000;
    localparam logic [31:0] PRIV_B_NET  = 32'hAC10_0000;
    localparam logic [31:0] PRIV_C_MASK = 32'hFFFF_0000;
    localparam logic [31:0] PRIV_C_NET  = 32'hC0A8_0000;

    // Input word
    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_csp_in;

    // Result word
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] network_addr;
        logic [31:0] host_lo;
        logic [31:0] host_hi;
        logic [31:0] host_total;
        logic [5:0]  prefix_len;
        logic        is_private;
    } t_csp_out;

    // Configuration register set
    typedef struct packed {
        logic        scope_mode;
        logic [31:0] max_hosts;
        logic        permit_remote;
        logic        confirmed;
    } t_csp_cfg;

    // Parsed text handed from parser to resolver
    typedef struct packed {
        logic        mode;
        t_status     parse_status;
        logic [31:0] addr;
        logic [5:0]  prefix;
    } t_csp_fin;

endpackage

>>> src/csp_cfg.sv
// ----------------------------------------------------------------------------
// csp_cfg
// Configuration register file; takes one write per cycle.
// ----------------------------------------------------------------------------
module csp_cfg
    import csp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_csp_cfg             o_cfg
);

    t_csp_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scope_mode    <= MODE_CUSTOM;
            r_cfg.max_hosts     <= MAX_HOSTS_RST;
            r_cfg.permit_remote <= 1'b0;
            r_cfg.confirmed     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCOPE_MODE:    r_cfg.scope_mode    <= i_cfg_data[0];
                CFG_MAX_HOSTS:     r_cfg.max_hosts     <= i_cfg_data;
                CFG_PERMIT_REMOTE: r_cfg.permit_remote <= i_cfg_data[0];
                CFG_CONFIRMED:     r_cfg.confirmed     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/csp_parse.sv
// ----------------------------------------------------------------------------
// csp_parse
// Character parser: updates the text accumulators one word per cycle unless
// stalled; the last character registers closed address, prefix, parse status.
// ----------------------------------------------------------------------------
module csp_parse
    import csp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_mode,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_csp_in  i_data,
    output logic     o_fin_valid,
    input  logic     i_fin_ready,
    output t_csp_fin o_fin
);

    logic [7:0]  r_octet_acc,        n_octet_acc;
    logic        r_octet_has_digit,  n_octet_has_digit;
    logic [1:0]  r_dot_count,        n_dot_count;
    logic [31:0] r_addr_acc,         n_addr_acc;
    logic        r_addr_bad,         n_addr_bad;
    logic        r_at_first_char;
    logic        r_seen_slash,       n_seen_slash;
    logic        r_slash_first,      n_slash_first;
    logic [5:0]  r_prefix_acc,       n_prefix_acc;
    logic        r_prefix_has_digit, n_prefix_has_digit;
    t_perr       r_prefix_err,       n_prefix_err;
    logic        r_fin_valid;
    t_csp_fin    r_fin,              n_fin;

    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] octet_v;
    logic [9:0]  prefix_v;
    logic        after;
    logic        fin_bad;

    assign accept      = i_valid && o_ready;
    assign o_ready     = !r_fin_valid || i_fin_ready;
    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    assign is_digit = (i_data.text_char >= CH_ZERO) && (i_data.text_char <= CH_NINE);
    assign digit    = 4'(i_data.text_char - CH_ZERO);
    assign octet_v  = {4'd0, r_octet_acc} * 12'd10 + {8'd0, digit};
    assign prefix_v = {4'd0, r_prefix_acc} * 10'd10 + {6'd0, digit};

    // Step the accumulators for one character
    always_comb begin
        n_octet_acc        = r_octet_acc;
        n_octet_has_digit  = r_octet_has_digit;
        n_dot_count        = r_dot_count;
        n_addr_acc         = r_addr_acc;
        n_addr_bad         = r_addr_bad;
        n_seen_slash       = r_seen_slash;
        n_slash_first      = r_slash_first;
        n_prefix_acc       = r_prefix_acc;
        n_prefix_has_digit = r_prefix_has_digit;
        n_prefix_err       = r_prefix_err;

        if (r_seen_slash) begin
            // Prefix digits; the first error sticks
            if (r_prefix_err == PERR_NONE) begin
                if (is_digit) begin
                    if (prefix_v > PREFIX_MAX) begin
                        n_prefix_err = PERR_OVER;
                    end else begin
                        n_prefix_acc       = prefix_v[5:0];
                        n_prefix_has_digit = 1'b1;
                    end
                end else begin
                    n_prefix_err = PERR_CHAR;
                end
            end
        end else if (i_mode == MODE_CUSTOM && i_data.text_char == CH_SLASH) begin
            // Slash closes the address
            if (r_at_first_char) begin
                n_slash_first = 1'b1;
            end
            n_seen_slash = 1'b1;
            if (!r_octet_has_digit || r_dot_count != LAST_DOT) begin
                n_addr_bad = 1'b1;
            end
            n_addr_acc = {r_addr_acc[23:0], r_octet_acc};
        end else if (is_digit) begin
            if (octet_v > OCTET_MAX) begin
                n_addr_bad = 1'b1;
            end else begin
                n_octet_acc       = octet_v[7:0];
                n_octet_has_digit = 1'b1;
            end
        end else if (i_data.text_char == CH_DOT) begin
            if (!r_octet_has_digit || r_dot_count == LAST_DOT) begin
                n_addr_bad = 1'b1;
            end else begin
                n_addr_acc        = {r_addr_acc[23:0], r_octet_acc};
                n_dot_count       = r_dot_count + 2'd1;
                n_octet_acc       = 8'd0;
                n_octet_has_digit = 1'b0;
            end
        end else begin
            n_addr_bad = 1'b1;
        end
    end

    // Close the text at the last character
    always_comb begin
        after   = n_prefix_has_digit || (n_prefix_err != PERR_NONE);
        fin_bad = n_addr_bad;
        n_fin.mode         = i_mode;
        n_fin.parse_status = ST_OK;
        n_fin.addr         = n_addr_acc;
        n_fin.prefix       = n_prefix_acc;
        if (i_mode == MODE_CUSTOM) begin
            if (!n_seen_slash || n_slash_first || !after) begin
                n_fin.parse_status = ST_NO_PREFIX;
            end else if (n_addr_bad) begin
                n_fin.parse_status = ST_BAD_ADDR;
            end else if (n_prefix_err == PERR_CHAR) begin
                n_fin.parse_status = ST_BAD_PREFIX_CHAR;
            end else if (n_prefix_err == PERR_OVER) begin
                n_fin.parse_status = ST_PREFIX_OVER;
            end
        end else begin
            n_fin.prefix = ADAPTER_PREFIX;
            if (n_seen_slash) begin
                fin_bad = 1'b1;
            end else begin
                if (!n_octet_has_digit || n_dot_count != LAST_DOT) begin
                    fin_bad = 1'b1;
                end
                n_fin.addr = {n_addr_acc[23:0], n_octet_acc};
            end
            if (fin_bad) begin
                n_fin.parse_status = ST_BAD_ADDR;
            end
        end
    end

    // Hold text state; clear it after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octet_acc        <= 8'd0;
            r_octet_has_digit  <= 1'b0;
            r_dot_count        <= 2'd0;
            r_addr_acc         <= 32'd0;
            r_addr_bad         <= 1'b0;
            r_at_first_char    <= 1'b1;
            r_seen_slash       <= 1'b0;
            r_slash_first      <= 1'b0;
            r_prefix_acc       <= 6'd0;
            r_prefix_has_digit <= 1'b0;
            r_prefix_err       <= PERR_NONE;
        end else if (accept) begin
            if (i_data.last_char) begin
                r_octet_acc        <= 8'd0;
                r_octet_has_digit  <= 1'b0;
                r_dot_count        <= 2'd0;
                r_addr_acc         <= 32'd0;
                r_addr_bad         <= 1'b0;
                r_at_first_char    <= 1'b1;
                r_seen_slash       <= 1'b0;
                r_slash_first      <= 1'b0;
                r_prefix_acc       <= 6'd0;
                r_prefix_has_digit <= 1'b0;
                r_prefix_err       <= PERR_NONE;
            end else begin
                r_octet_acc        <= n_octet_acc;
                r_octet_has_digit  <= n_octet_has_digit;
                r_dot_count        <= n_dot_count;
                r_addr_acc         <= n_addr_acc;
                r_addr_bad         <= n_addr_bad;
                r_at_first_char    <= 1'b0;
                r_seen_slash       <= n_seen_slash;
                r_slash_first      <= n_slash_first;
                r_prefix_acc       <= n_prefix_acc;
                r_prefix_has_digit <= n_prefix_has_digit;
                r_prefix_err       <= n_prefix_err;
            end
        end
    end

    // Hold the closed text until the resolver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (accept && i_data.last_char) begin
            r_fin_valid <= 1'b1;
        end else if (i_fin_ready) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_data.last_char) begin
            r_fin <= n_fin;
        end
    end

endmodule

>>> src/csp_resolve.sv
// ----------------------------------------------------------------------------
// csp_resolve
// Range resolver: derives network, hosts and count from address and prefix,
// applies the cap and scope policy, and holds the result word.
// ----------------------------------------------------------------------------
module csp_resolve
    import csp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_csp_cfg i_cfg,
    input  logic     i_fin_valid,
    output logic     o_fin_ready,
    input  t_csp_fin i_fin,
    output logic     o_valid,
    input  logic     i_ready,
    output t_csp_out o_data
);

    logic        r_out_valid;
    t_csp_out    r_out, n_out;

    logic [31:0] mask;
    logic [31:0] net;
    logic [31:0] host_bits;
    logic [31:0] count;
    logic        priv;
    logic        load;

    assign o_fin_ready = !r_out_valid || i_ready;
    assign load        = i_fin_valid && o_fin_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // Derive the range
    assign mask      = ~(32'hFFFF_FFFF >> i_fin.prefix);
    assign net       = i_fin.addr & mask;
    assign host_bits = ~mask;
    assign count     = (i_fin.prefix >= PREFIX_FULL) ? 32'd0 : host_bits - 32'd1;
    assign priv      = ((net & PRIV_A_MASK) == PRIV_A_NET)
                    || ((net & PRIV_B_MASK) == PRIV_B_NET)
                    || ((net & PRIV_C_MASK) == PRIV_C_NET);

    // Apply policy in the order of the mode
    always_comb begin
        n_out = '0;
        n_out.status = i_fin.parse_status;
        if (i_fin.parse_status == ST_OK) begin
            if (i_fin.mode == MODE_CUSTOM) begin
                if (count > i_cfg.max_hosts) begin
                    n_out.status = ST_CAP_EXCEEDED;
                end else if (!priv && !i_cfg.permit_remote) begin
                    n_out.status = ST_NOT_ALLOWED;
                end else if (!priv && !i_cfg.confirmed) begin
                    n_out.status = ST_NOT_CONFIRMED;
                end
            end else begin
                if (!priv) begin
                    n_out.status = ST_NON_LOCAL;
                end else if (count > i_cfg.max_hosts) begin
                    n_out.status = ST_CAP_EXCEEDED;
                end
            end
            n_out.network_addr = net;
            n_out.host_lo      = net + 32'd1;
            n_out.host_hi      = (net | host_bits) - 32'd1;
            n_out.host_total   = count;
            n_out.prefix_len   = i_fin.prefix;
            n_out.is_private   = priv;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

>>> src/cidr_scope_parser.sv
// ----------------------------------------------------------------------------
// cidr_scope_parser
// Streaming parser for one dotted IPv4 text with CIDR range and scope checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready/i_data) carries one text character per
//   word with a last flag. Only the last character produces a result word on
//   the output channel (o_valid/i_ready/o_data): status, network, first and
//   last host, host count, prefix length and private flag.
//   The configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_index/
//   i_cfg_data) is always ready; write it only while no text is in flight.
//   Throughput: one character per cycle, sustained while the receiver keeps
//   up, back to back across texts. The parser register and the result
//   register each hold one word, so a new text streams in while the previous
//   result waits. The last character closes the text into the parser
//   register, and the resolved range is held in the result register.
//   When the receiver stalls, the result holds and the parser holds one
//   closed text behind it; o_ready drops only when both are full.
//   Reset clears the text state, empties both registers and sets the
//   configuration to custom mode, cap 256, non-local denied, unconfirmed.
// ----------------------------------------------------------------------------
module cidr_scope_parser
    import csp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_csp_in              i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_csp_out             o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_csp_cfg cfg;
    t_csp_fin fin;
    logic     fin_valid;
    logic     fin_ready;

    // Configuration registers
    csp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Character parser
    csp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (cfg.scope_mode),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    // Range resolver and result register
    csp_resolve u_resolve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fin_valid (fin_valid),
        .o_fin_ready (fin_ready),
        .i_fin       (fin),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

>>> src/csp_checker.sv
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks of the CIDR scope parser, bound to the top level.
// ----------------------------------------------------------------------------
module csp_checker
    import csp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_ready,
    input t_csp_out o_data
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // Parse failures carry no range
    a_parse_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_NO_PREFIX || o_data.status == ST_BAD_ADDR
            || o_data.status == ST_BAD_PREFIX_CHAR || o_data.status == ST_PREFIX_OVER)
        |-> o_data.network_addr == 32'd0 && o_data.host_total == 32'd0
            && o_data.prefix_len == 6'd0 && !o_data.is_private)
        else $error("parse failure with nonzero range");

    // Resolved ranges are consistent
    a_range_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == ST_OK || o_data.status == ST_CAP_EXCEEDED
            || o_data.status == ST_NON_LOCAL || o_data.status == ST_NOT_ALLOWED
            || o_data.status == ST_NOT_CONFIRMED)
        |-> o_data.host_lo == o_data.network_addr + 32'd1
            && o_data.prefix_len <= PREFIX_FULL)
        else $error("inconsistent resolved range");

endmodule

bind cidr_scope_parser csp_checker u_csp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
